FILE: rtl/lkv_pkg.sv
package lkv_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [WORD_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } lkv_cmd_e;

  typedef struct packed {
    lkv_cmd_e                 command;
    logic signed [WORD_W-1:0] lookup_key;
    logic signed [WORD_W-1:0] store_value;
  } lkv_req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [WORD_W-1:0] read_value;
  } lkv_rsp_t;

  typedef struct packed {
    logic hit;
    logic data_we;
  } lkv_ctl_t;

endpackage

FILE: rtl/lkv_ram.sv
module lkv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lkv_dir.sv
module lkv_dir import lkv_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  lkv_req_t                   req_i,
  input  logic [CAP_W-1:0]           cap_i,
  output lkv_ctl_t                   ctl_o,
  output logic [$clog2(ENTRIES)-1:0] hit_idx_o,
  output logic [$clog2(ENTRIES)-1:0] wr_idx_o
);

  localparam int unsigned IW    = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [WORD_W-1:0]  key_q [ENTRIES];
  logic [IW-1:0]      rank_q [ENTRIES];
  logic [IW-1:0]      rank_d [ENTRIES];
  logic [CNT_W-1:0]   used_q, used_d;

  logic [ENTRIES-1:0] match;
  logic               hit;
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      old_rank;
  logic [CMP_W-1:0]   cap_eff;
  logic               full;
  logic [CNT_W-1:0]   used_m1;
  logic [IW-1:0]      evict_idx;
  logic [IW-1:0]      free_idx;
  logic [IW-1:0]      slot;
  logic               is_put;
  logic               key_we;

  always_comb begin
    match   = '0;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (key_q[i] == req_i.lookup_key);
      if (match[i]) begin
        hit_idx = IW'(i);
      end
    end
  end

  assign hit      = |match;
  assign old_rank = rank_q[hit_idx];
  assign is_put   = (req_i.command == CMD_PUT);

  always_comb begin
    cap_eff = CMP_W'(cap_i);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end
    if (cap_eff > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end
  end

  assign full    = CMP_W'(used_q) >= cap_eff;
  assign used_m1 = used_q - CNT_W'(1);

  always_comb begin
    evict_idx = '0;
    free_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (rank_q[i] == used_m1[IW-1:0])) begin
        evict_idx = IW'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign slot = full ? evict_idx : free_idx;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    used_d  = used_q;
    key_we  = 1'b0;
    if (valid_i) begin
      if (hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && (rank_q[i] < old_rank)) begin
            rank_d[i] = rank_q[i] + IW'(1);
          end
        end
        rank_d[hit_idx] = '0;
      end else if (is_put) begin
        key_we = 1'b1;
        if (!full) begin
          used_d = used_q + CNT_W'(1);
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && (IW'(i) != slot)) begin
            rank_d[i] = rank_q[i] + IW'(1);
          end
        end
        valid_d[slot] = 1'b1;
        rank_d[slot]  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      used_q  <= used_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q[slot] <= req_i.lookup_key;
    end
  end

  assign ctl_o.hit     = hit;
  assign ctl_o.data_we = valid_i && is_put;
  assign hit_idx_o     = hit_idx;
  assign wr_idx_o      = hit ? hit_idx : slot;

endmodule

FILE: rtl/lru_key_value_cache.sv
// Fully associative key-value cache with LRU replacement. A request is
// taken in every clock cycle (busy never rises): it is registered, then
// in the next cycle all keys are compared in parallel and the valid bits,
// recency ranks and key registers are updated; the data word sits in a
// RAM with registered read, so a get returns its result on rsp_valid_o
// from the registers behind the request register, for one cycle only.
// A put returns nothing. The receiver cannot stall results. Capacity may
// be written at any time the cache is idle; cfg_ready_o is always high.
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  lkv_req_t         req_i,
  output logic             rsp_valid_o,
  output lkv_rsp_t         rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(ENTRIES);

  logic [CAP_W-1:0]  cap_q;
  logic              req_vld_q;
  lkv_req_t          req_q;
  lkv_ctl_t          ctl;
  logic [IW-1:0]     hit_idx;
  logic [IW-1:0]     wr_idx;
  logic              get_vld_q;
  logic              hit_q;
  logic [WORD_W-1:0] rdata;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      get_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start && !busy;
      get_vld_q <= req_vld_q && (req_q.command == CMD_GET);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    hit_q <= ctl.hit;
  end

  lkv_dir #(
    .ENTRIES (ENTRIES)
  ) u_dir (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (req_vld_q),
    .req_i     (req_q),
    .cap_i     (cap_q),
    .ctl_o     (ctl),
    .hit_idx_o (hit_idx),
    .wr_idx_o  (wr_idx)
  );

  lkv_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (ctl.data_we),
    .waddr_i (wr_idx),
    .wdata_i (req_q.store_value),
    .raddr_i (hit_idx),
    .rdata_o (rdata)
  );

  assign rsp_valid_o      = get_vld_q;
  assign rsp_o.hit        = hit_q;
  assign rsp_o.read_value = hit_q ? rdata : MISS_VALUE;

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_pkg::*;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned STALL_MAX  = 500;
  localparam int unsigned DRAIN_WAIT = 4;

  typedef struct {
    lkv_req_t    req;
    int unsigned gap;
  } cache_op_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  lkv_req_t         req = '0;
  logic             rsp_valid;
  lkv_rsp_t         rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  lru_key_value_cache #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  cache_op_t   op_backlog[$];
  lkv_rsp_t    exp_reads[$];
  int unsigned n_pushed   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_fail     = 0;
  int unsigned n_gets     = 0;
  int unsigned n_hits     = 0;
  int unsigned n_puts     = 0;
  int unsigned n_evicts   = 0;
  int unsigned n_cfg      = 0;
  logic        req_taken  = 1'b0;
  logic        cfg_taken  = 1'b0;

  // shadow cache state
  logic             sh_valid[ENTRIES];
  logic [31:0]      sh_key[ENTRIES];
  logic [31:0]      sh_data[ENTRIES];
  int unsigned      sh_rank[ENTRIES];
  int unsigned      sh_used = 0;
  logic [CAP_W-1:0] sh_cap = CAP_RESET;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      sh_valid[i] = 1'b0;
      sh_key[i]   = '0;
      sh_data[i]  = '0;
      sh_rank[i]  = 0;
    end
  end

  function automatic void make_most_recent(input int idx);
    int unsigned old_rank;
    old_rank = sh_rank[idx];
    for (int i = 0; i < ENTRIES; i++) begin
      if (sh_valid[i] && sh_rank[i] < old_rank) sh_rank[i] = sh_rank[i] + 1;
    end
    sh_rank[idx] = 0;
  endfunction

  function automatic void cache_access(input lkv_req_t r);
    int          hit_idx;
    int          slot;
    int unsigned eff_cap;
    lkv_rsp_t    res;
    hit_idx = -1;
    slot    = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_idx < 0 && sh_valid[i] && sh_key[i] == r.lookup_key) hit_idx = i;
    end
    if (r.command == CMD_GET) begin
      n_gets++;
      if (hit_idx >= 0) begin
        n_hits++;
        res.hit        = 1'b1;
        res.read_value = sh_data[hit_idx];
        make_most_recent(hit_idx);
      end else begin
        res.hit        = 1'b0;
        res.read_value = MISS_VALUE;
      end
      exp_reads.push_back(res);
    end else begin
      n_puts++;
      if (hit_idx >= 0) begin
        sh_data[hit_idx] = r.store_value;
        make_most_recent(hit_idx);
      end else begin
        eff_cap = (sh_cap == 0) ? 1 : ((sh_cap > ENTRIES) ? ENTRIES : sh_cap);
        if (sh_used >= eff_cap && sh_used > 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && sh_valid[i] && sh_rank[i] == sh_used - 1) slot = i;
          end
          if (slot >= 0) begin
            sh_valid[slot] = 1'b0;
            n_evicts++;
          end
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !sh_valid[i]) slot = i;
          end
          if (slot >= 0) sh_used++;
        end
        if (slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (sh_valid[i]) sh_rank[i] = sh_rank[i] + 1;
          end
          sh_valid[slot] = 1'b1;
          sh_key[slot]   = r.lookup_key;
          sh_data[slot]  = r.store_value;
          sh_rank[slot]  = 0;
        end
      end
    end
  endfunction

  // driver
  always @(negedge clk_i) begin : drive
    logic        nxt_start;
    lkv_req_t    nxt_req;
    cache_op_t   cur;
    logic        have_cur;
    int unsigned gap_left;
    if (rst_ni) begin
      nxt_start = start;
      nxt_req   = req;
      if (!start || req_taken) begin
        nxt_start = 1'b0;
        if (!have_cur && op_backlog.size() > 0) begin
          cur      = op_backlog.pop_front();
          have_cur = 1'b1;
          gap_left = cur.gap;
        end
        if (have_cur) begin
          if (gap_left == 0) begin
            nxt_start = 1'b1;
            nxt_req   = cur.req;
            have_cur  = 1'b0;
          end else begin
            gap_left--;
          end
        end
      end
      start <= nxt_start;
      req   <= nxt_req;
    end else begin
      have_cur = 1'b0;
      gap_left = 0;
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin : monitor
    lkv_rsp_t want;
    if (rst_ni) begin
      if (rsp_valid) begin
        if (exp_reads.size() == 0) begin
          $error("result with no get outstanding: hit=%0b read_value=%h",
                 rsp.hit, rsp.read_value);
          n_fail++;
        end else begin
          want = exp_reads.pop_front();
          if (rsp.hit !== want.hit) begin
            $error("hit mismatch: expected %0b, actual %0b", want.hit, rsp.hit);
            n_fail++;
          end
          if (rsp.read_value !== want.read_value) begin
            $error("read_value mismatch: expected %h, actual %h",
                   want.read_value, rsp.read_value);
            n_fail++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        sh_cap = cfg_data;
        n_cfg++;
      end
      if (start && !busy) begin
        cache_access(req);
        n_accepted++;
      end
      req_taken <= start && !busy;
      cfg_taken <= cfg_valid && cfg_ready;
    end
  end

  always @(posedge clk_i) begin : watchdog
    int unsigned stall_cycles;
    if (!rst_ni || (start && !busy) || rsp_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic queue_op(input lkv_cmd_e c, input logic [31:0] k, input logic [31:0] v,
                          input int unsigned gap);
    cache_op_t op;
    op.req.command     = c;
    op.req.lookup_key  = k;
    op.req.store_value = v;
    op.gap             = gap;
    op_backlog.push_back(op);
    n_pushed++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (n_accepted != n_pushed || exp_reads.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input logic [CAP_W-1:0] cap, input int unsigned count);
    logic [31:0] key_pool[$];
    logic [31:0] k;
    logic [31:0] v;
    int unsigned gap;
    write_capacity(cap);
    key_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
    while (key_pool.size() < cap + 3) key_pool.push_back($urandom);
    for (int i = 0; i < count; i++) begin
      gap = ((i % 40) < 12) ? 0 : $urandom_range(0, 5);
      k   = ($urandom_range(0, 9) == 0) ? $urandom
                                        : key_pool[$urandom_range(0, key_pool.size() - 1)];
      case ($urandom_range(0, 7))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7fff_ffff;
        default: v = $urandom;
      endcase
      queue_op(lkv_cmd_e'($urandom_range(0, 1)), k, v, gap);
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset capacity
    queue_op(CMD_GET, 32'h0000_0000, 32'h0, 0);
    queue_op(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000, 1);
    queue_op(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff, 0);
    queue_op(CMD_PUT, 32'h0000_0000, 32'hffff_ffff, 2);
    queue_op(CMD_PUT, 32'hffff_ffff, 32'h0000_0000, 0);
    queue_op(CMD_GET, 32'h7fff_ffff, 32'h0, 0);
    queue_op(CMD_GET, 32'h8000_0000, 32'h0, 3);
    queue_op(CMD_GET, 32'h0000_0000, 32'h0, 0);
    queue_op(CMD_GET, 32'hffff_ffff, 32'h0, 0);
    queue_op(CMD_GET, 32'h0000_0001, 32'h0, 1);
    queue_op(CMD_PUT, 32'h8000_0000, 32'h1234_5678, 0);
    queue_op(CMD_GET, 32'h8000_0000, 32'h0, 0);
    queue_op(CMD_GET, 32'h8000_0000, 32'h0, 0);
    queue_op(CMD_PUT, 32'h0000_0000, 32'h5a5a_5a5a, 2);
    queue_op(CMD_GET, 32'h0000_0000, 32'h0, 0);
    wait_idle();

    // capacity dropped below the fill level
    write_capacity(5'd1);
    queue_op(CMD_PUT, 32'h0000_0005, 32'h0000_0055, 0);
    queue_op(CMD_GET, 32'h0000_0005, 32'h0, 0);
    queue_op(CMD_GET, 32'h7fff_ffff, 32'h0, 1);
    queue_op(CMD_PUT, 32'h0000_0006, 32'h0000_0066, 0);
    queue_op(CMD_GET, 32'h0000_0005, 32'h0, 0);
    queue_op(CMD_GET, 32'h0000_0006, 32'h0, 0);
    queue_op(CMD_PUT, 32'h0000_0006, 32'ha5a5_a5a5, 0);
    queue_op(CMD_GET, 32'h0000_0006, 32'h0, 0);
    wait_idle();

    run_random(5'd16, 52);
    run_random(5'd4, 52);
    run_random(5'd1, 52);
    run_random(5'd9, 52);
    run_random(5'd2, 52);
    run_random(5'd16, 52);
    run_random(5'd13, 52);
    run_random(5'd6, 52);

    repeat (8) @(negedge clk_i);
    $display("Ran %0d transactions: %0d gets (%0d hits), %0d puts, %0d evictions,",
             n_accepted, n_gets, n_hits, n_puts, n_evicts);
    $display("across %0d capacity writes spanning capacities 1 to 16.", n_cfg);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
